>>> rtl/hexik_pkg.sv
// Shared constants, geometry tables and FSM types for the hexapod servo IK block.
// No dependencies; imported by every module of the block.
package hexik_pkg;

	localparam int LEG_COUNT    = 6;
	localparam int LEG_W        = 3;
	localparam int CORDIC_STEPS = 16;
	localparam int CSTEP_W      = 5;
	localparam int ANG_W        = 32;   // CORDIC angle, Q28 radians
	localparam int TRIG_W       = 18;   // sin/cos out, Q16
	localparam int R_W          = 20;   // rotation terms, Q16
	localparam int Q_W          = 26;   // joint coordinates, 1/16384 mm
	localparam int D_W          = 27;   // leg vector components
	localparam int SQ_W         = 54;   // sum of squares
	localparam int LEN_W        = 27;   // leg length
	localparam int SA_W         = 17;   // servo angle, degrees Q8.8
	localparam int MUL_A_W      = 36;
	localparam int MUL_B_W      = 28;
	localparam int PROD_W       = 64;
	localparam int STEP_W       = 5;

	localparam logic signed [ANG_W-1:0] PI_Q28      = 32'sd843314857;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
	localparam logic signed [ANG_W-1:0] GAIN_Q28    = 32'sd163008219;
	localparam logic signed [MUL_A_W-1:0] DEG_TO_RAD_Q36 = 36'sd1199381129;

	localparam logic [1:0] SOLVE_CONVERGED = 2'd0;
	localparam logic [1:0] SOLVE_EXHAUSTED = 2'd1;
	localparam logic [1:0] SOLVE_PINNED    = 2'd2;

	typedef enum logic [2:0] {
		CFG_LEG_LENGTH,
		CFG_HORN_LENGTH,
		CFG_LENGTH_TOL,
		CFG_ANGLE_LIMIT,
		CFG_MAX_ITER,
		CFG_PULSE_GAIN
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRIG,
		ST_ROT,
		ST_LEG_Q,
		ST_ANG,
		ST_HORN,
		ST_SQRT,
		ST_DECIDE,
		ST_PULSE
	} state_t;

	function automatic logic signed [ANG_W-1:0] atan_q28(input logic [CSTEP_W-1:0] i);
		logic signed [ANG_W-1:0] v;
		case (i)
			5'd0:  v = 32'sd210828714;
			5'd1:  v = 32'sd124459457;
			5'd2:  v = 32'sd65760959;
			5'd3:  v = 32'sd33381290;
			5'd4:  v = 32'sd16755422;
			5'd5:  v = 32'sd8385879;
			5'd6:  v = 32'sd4193963;
			5'd7:  v = 32'sd2097109;
			5'd8:  v = 32'sd1048571;
			5'd9:  v = 32'sd524287;
			5'd10: v = 32'sd262144;
			5'd11: v = 32'sd131072;
			5'd12: v = 32'sd65536;
			5'd13: v = 32'sd32768;
			5'd14: v = 32'sd16384;
			5'd15: v = 32'sd8192;
			5'd16: v = 32'sd4096;
			5'd17: v = 32'sd2048;
			5'd18: v = 32'sd1024;
			5'd19: v = 32'sd512;
			5'd20: v = 32'sd256;
			5'd21: v = 32'sd128;
			5'd22: v = 32'sd64;
			5'd23: v = 32'sd32;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [13:0] base_x(input logic [LEG_W-1:0] k);
		logic signed [13:0] v;
		case (k)
			3'd0, 3'd1: v = 14'sd5632;
			3'd2, 3'd5: v = -14'sd876;
			3'd3, 3'd4: v = -14'sd4756;
			default:    v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [13:0] base_y(input logic [LEG_W-1:0] k);
		logic signed [13:0] v;
		case (k)
			3'd0:    v = -14'sd2240;
			3'd1:    v = 14'sd2240;
			3'd2:    v = 14'sd5997;
			3'd3:    v = 14'sd3757;
			3'd4:    v = -14'sd3757;
			3'd5:    v = -14'sd5997;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [13:0] plat_x(input logic [LEG_W-1:0] k);
		logic signed [13:0] v;
		case (k)
			3'd0, 3'd1, 3'd2, 3'd5: v = (k == 3'd2 || k == 3'd5) ? 14'sd2219 : 14'sd2773;
			3'd3, 3'd4:             v = -14'sd4992;
			default:                v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [13:0] plat_y(input logic [LEG_W-1:0] k);
		logic signed [13:0] v;
		case (k)
			3'd0:    v = -14'sd4163;
			3'd1:    v = 14'sd4163;
			3'd2:    v = 14'sd4483;
			3'd3:    v = 14'sd320;
			3'd4:    v = -14'sd320;
			3'd5:    v = -14'sd4483;
			default: v = '0;
		endcase
		return v;
	endfunction

	// horn direction, Q16
	function automatic logic signed [TRIG_W-1:0] dir_c(input logic [LEG_W-1:0] k);
		logic signed [TRIG_W-1:0] v;
		case (k)
			3'd0, 3'd1: v = '0;
			3'd2, 3'd5: v = -18'sd56756;
			3'd3, 3'd4: v = 18'sd56756;
			default:    v = 18'sd65536;
		endcase
		return v;
	endfunction

	function automatic logic signed [TRIG_W-1:0] dir_s(input logic [LEG_W-1:0] k);
		logic signed [TRIG_W-1:0] v;
		case (k)
			3'd0:       v = 18'sd65536;
			3'd1:       v = -18'sd65536;
			3'd2, 3'd4: v = -18'sd32768;
			3'd3, 3'd5: v = 18'sd32768;
			default:    v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [10:0] neutral_us(input logic [LEG_W-1:0] k);
		logic [10:0] v;
		case (k)
			3'd0, 3'd1, 3'd4: v = 11'd1650;
			3'd2, 3'd3:       v = 11'd1625;
			3'd5:             v = 11'd1575;
			default:          v = 11'd1500;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/hexapod_servo_inverse_kinematics.sv
// Top level: pose in, six servo pulse widths out, one shared multiplier under a sequencer.
// Depends on hexik_pkg, hexik_cordic, hexik_isqrt.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  pose in  | start & !busy          | pos_x pos_y pos_z yaw/pitch/roll_angle
//  result   | result_strobe (1 clk)  | leg_index pulse_width solve_status last_leg
//  config   | cfg_we                 | cfg_index cfg_data
//
// A pose runs the trig and rotation phases once, then per leg the joint phase, k bisection
// steps and the pulse phase; the CORDIC wait and the root in each step dominate.
// busy stays high from acceptance until the sixth result strobe. Results come out one
// per leg, each strobed for one cycle; the receiver cannot stall. arst_n clears the
// sequencer and loads the register defaults.
module hexapod_servo_inverse_kinematics import hexik_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic signed [15:0] yaw_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] roll_angle,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               result_strobe,
	output logic [LEG_W-1:0]   leg_index,
	output logic [11:0]        pulse_width,
	output logic [1:0]         solve_status,
	output logic               last_leg
);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	logic [15:0] leg_len_q, horn_q, gain_q;
	logic [7:0]  tol_q;
	logic [6:0]  alim_q;
	logic [5:0]  max_it_q;

	logic signed [15:0] tx_q, ty_q, tz_q, yaw_q, pitch_q, roll_q;
	logic signed [TRIG_W-1:0] cps_q, sps_q, cth_q, sth_q, cph_q, sph_q, ca_q, sa_q;
	logic signed [R_W-1:0] r00_q, r01_q, r10_q, r11_q, r20_q, r21_q, t1_q, t2_q;
	logic signed [Q_W-1:0] qx_q, qy_q, qz_q;
	logic signed [MUL_A_W-1:0] acc_q, hca_q;
	logic signed [D_W-1:0] dx_q, dy_q, dz_q;
	logic [SQ_W-1:0] sum_q;
	logic signed [SA_W-1:0] lo_q, hi_q, ang_q, lim_q;
	logic [5:0] n_q;
	logic [1:0] status_q;
	logic [LEG_W-1:0] leg_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  prod_r8, prod_r16, prod_r24, acc_r8, w_full, w_rnd;

	logic                     cordic_start, cordic_done;
	logic signed [ANG_W-1:0]  cordic_angle;
	logic signed [TRIG_W-1:0] cordic_cos, cordic_sin;
	logic                     sqrt_start, sqrt_done;
	logic [SQ_W-1:0]          radicand;
	logic [LEN_W-1:0]         len;

	logic signed [LEN_W+1:0] len_diff, tol_s;
	logic                    conv, below, pin, exhaust;
	logic signed [SA_W-1:0]  new_lo, new_hi, mid;
	logic [6:0]              n_next;
	logic [6:0]              lim_deg;
	logic signed [15:0]      pose_ang;
	logic [11:0]             pulse_sat;

	hexik_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.angle   (cordic_angle),
		.done    (cordic_done),
		.cos_val (cordic_cos),
		.sin_val (cordic_sin)
	);

	hexik_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.done     (sqrt_done),
		.root     (len)
	);

	assign busy = (state_q != ST_IDLE);

	// rounded views of the shared product
	assign prod_r8  = (prod_q + 64'sd128) >>> 8;
	assign prod_r16 = (prod_q + 64'sd32768) >>> 16;
	assign prod_r24 = (prod_q + 64'sd8388608) >>> 24;
	assign acc_r8   = (PROD_W'(acc_q) + prod_q + 64'sd128) >>> 8;
	assign radicand = sum_q + prod_q[SQ_W-1:0];

	// bisection decision
	assign len_diff = $signed({2'b00, len}) - $signed({5'b0, leg_len_q, 8'b0});
	assign tol_s    = $signed({13'b0, tol_q, 8'b0});
	assign conv     = (len_diff <= tol_s) && (-len_diff <= tol_s);
	assign below    = len < {leg_len_q, 8'b0};
	assign new_hi   = below ? ang_q : hi_q;
	assign new_lo   = below ? lo_q : ang_q;
	assign pin      = (new_lo >= lim_q) || (new_hi <= -lim_q);
	assign mid      = new_lo + ((new_hi - new_lo) >>> 1);
	assign n_next   = {1'b0, n_q} + 7'd1;
	assign exhaust  = n_next >= {1'b0, max_it_q};

	assign lim_deg = (alim_q == 7'd0) ? 7'd1 : (alim_q > 7'd90) ? 7'd90 : alim_q;

	assign w_full = leg_q[0] ? ($signed({37'b0, neutral_us(leg_q), 16'b0}) - prod_q)
	                         : ($signed({37'b0, neutral_us(leg_q), 16'b0}) + prod_q);
	assign w_rnd  = (w_full + 64'sd32768) >>> 16;
	assign pulse_sat = (w_rnd < 0) ? 12'd0 : (w_rnd > 64'sd4095) ? 12'd4095 : w_rnd[11:0];

	// next state
	always_comb begin
		state_d = state_q;
		step_d  = step_q + 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				step_d = '0;
				if (start) state_d = ST_TRIG;
			end
			ST_TRIG: begin
				if (step_q[0] && !cordic_done) begin
					step_d = step_q;
				end else if (step_q[0] && step_q == STEP_W'(5)) begin
					state_d = ST_ROT;
					step_d  = '0;
				end
			end
			ST_ROT: begin
				if (step_q == STEP_W'(17)) begin
					state_d = ST_LEG_Q;
					step_d  = '0;
				end
			end
			ST_LEG_Q: begin
				if (step_q == STEP_W'(11)) begin
					state_d = (max_it_q == 6'd0) ? ST_PULSE : ST_ANG;
					step_d  = '0;
				end
			end
			ST_ANG: begin
				if (step_q == STEP_W'(2)) begin
					step_d = step_q;
					if (cordic_done) begin
						state_d = ST_HORN;
						step_d  = '0;
					end
				end
			end
			ST_HORN: begin
				if (step_q == STEP_W'(13)) begin
					state_d = ST_SQRT;
					step_d  = '0;
				end
			end
			ST_SQRT: begin
				step_d = '0;
				if (sqrt_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				step_d  = '0;
				state_d = (conv || pin || exhaust) ? ST_PULSE : ST_ANG;
			end
			ST_PULSE: begin
				if (step_q == STEP_W'(1)) begin
					step_d  = '0;
					state_d = (leg_q == LEG_W'(LEG_COUNT - 1)) ? ST_IDLE : ST_LEG_Q;
				end
			end
			default: begin
				state_d = ST_IDLE;
				step_d  = '0;
			end
		endcase
	end

	// unit controls and multiplier operands
	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		cordic_start = 1'b0;
		cordic_angle = '0;
		sqrt_start   = 1'b0;
		case (step_q[2:1])
			2'd0:    pose_ang = yaw_q;
			2'd1:    pose_ang = pitch_q;
			default: pose_ang = roll_q;
		endcase
		unique case (state_q)
			ST_TRIG: begin
				cordic_start = !step_q[0];
				cordic_angle = $signed({pose_ang, 15'b0}) + 32'sd0;
			end
			ST_ROT: begin
				case (step_q[4:1])
					4'd0:    begin mul_a = MUL_A_W'(cps_q); mul_b = MUL_B_W'(cth_q); end
					4'd1:    begin mul_a = MUL_A_W'(sps_q); mul_b = MUL_B_W'(cph_q); end
					4'd2:    begin mul_a = MUL_A_W'(cps_q); mul_b = MUL_B_W'(sth_q); end
					4'd3:    begin mul_a = MUL_A_W'(t2_q);  mul_b = MUL_B_W'(sph_q); end
					4'd4:    begin mul_a = MUL_A_W'(sps_q); mul_b = MUL_B_W'(cth_q); end
					4'd5:    begin mul_a = MUL_A_W'(cps_q); mul_b = MUL_B_W'(cph_q); end
					4'd6:    begin mul_a = MUL_A_W'(sps_q); mul_b = MUL_B_W'(sth_q); end
					4'd7:    begin mul_a = MUL_A_W'(t2_q);  mul_b = MUL_B_W'(sph_q); end
					default: begin mul_a = MUL_A_W'(cth_q); mul_b = MUL_B_W'(sph_q); end
				endcase
			end
			ST_LEG_Q: begin
				case (step_q[3:1])
					3'd0:    begin mul_a = MUL_A_W'(r00_q); mul_b = MUL_B_W'(plat_x(leg_q)); end
					3'd1:    begin mul_a = MUL_A_W'(r01_q); mul_b = MUL_B_W'(plat_y(leg_q)); end
					3'd2:    begin mul_a = MUL_A_W'(r10_q); mul_b = MUL_B_W'(plat_x(leg_q)); end
					3'd3:    begin mul_a = MUL_A_W'(r11_q); mul_b = MUL_B_W'(plat_y(leg_q)); end
					3'd4:    begin mul_a = MUL_A_W'(r20_q); mul_b = MUL_B_W'(plat_x(leg_q)); end
					default: begin mul_a = MUL_A_W'(r21_q); mul_b = MUL_B_W'(plat_y(leg_q)); end
				endcase
			end
			ST_ANG: begin
				mul_a        = DEG_TO_RAD_Q36;
				mul_b        = MUL_B_W'(ang_q);
				cordic_start = (step_q == STEP_W'(1));
				cordic_angle = prod_r16[ANG_W-1:0];
			end
			ST_HORN: begin
				case (step_q[3:1])
					3'd0:    begin mul_a = $signed({20'b0, horn_q}); mul_b = MUL_B_W'(ca_q); end
					3'd1:    begin mul_a = hca_q; mul_b = MUL_B_W'(dir_c(leg_q)); end
					3'd2:    begin mul_a = hca_q; mul_b = MUL_B_W'(dir_s(leg_q)); end
					3'd3:    begin mul_a = $signed({20'b0, horn_q}); mul_b = MUL_B_W'(sa_q); end
					3'd4:    begin mul_a = MUL_A_W'(dx_q); mul_b = MUL_B_W'(dx_q); end
					3'd5:    begin mul_a = MUL_A_W'(dy_q); mul_b = MUL_B_W'(dy_q); end
					default: begin mul_a = MUL_A_W'(dz_q); mul_b = MUL_B_W'(dz_q); end
				endcase
				sqrt_start = (step_q == STEP_W'(13));
			end
			ST_PULSE: begin
				mul_a = $signed({20'b0, gain_q});
				mul_b = MUL_B_W'(ang_q);
			end
			ST_IDLE, ST_SQRT, ST_DECIDE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			result_strobe <= 1'b0;
			leg_len_q     <= 16'd12480;
			horn_q        <= 16'd1504;
			tol_q         <= 8'd1;
			alim_q        <= 7'd45;
			max_it_q      <= 6'd10;
			gain_q        <= 16'd2276;
		end else begin
			state_q       <= state_d;
			step_q        <= step_d;
			result_strobe <= (state_q == ST_PULSE) && step_q[0];
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LEG_LENGTH:  leg_len_q <= cfg_data;
					CFG_HORN_LENGTH: horn_q    <= cfg_data;
					CFG_LENGTH_TOL:  tol_q     <= cfg_data[7:0];
					CFG_ANGLE_LIMIT: alim_q    <= cfg_data[6:0];
					CFG_MAX_ITER:    max_it_q  <= cfg_data[5:0];
					CFG_PULSE_GAIN:  gain_q    <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					tx_q    <= pos_x;
					ty_q    <= pos_y;
					tz_q    <= pos_z;
					yaw_q   <= yaw_angle;
					pitch_q <= pitch_angle;
					roll_q  <= roll_angle;
					lim_q   <= $signed({2'b0, lim_deg, 8'b0});
					leg_q   <= '0;
				end
			end
			ST_TRIG: begin
				if (step_q[0] && cordic_done) begin
					case (step_q[2:1])
						2'd0:    begin cps_q <= cordic_cos; sps_q <= cordic_sin; end
						2'd1:    begin cth_q <= cordic_cos; sth_q <= cordic_sin; end
						default: begin cph_q <= cordic_cos; sph_q <= cordic_sin; end
					endcase
				end
			end
			ST_ROT: begin
				if (step_q[0]) begin
					case (step_q[4:1])
						4'd0:    r00_q <= prod_r16[R_W-1:0];
						4'd1:    t1_q  <= prod_r16[R_W-1:0];
						4'd2:    t2_q  <= prod_r16[R_W-1:0];
						4'd3:    r01_q <= prod_r16[R_W-1:0] - t1_q;
						4'd4:    r10_q <= prod_r16[R_W-1:0];
						4'd5:    t1_q  <= prod_r16[R_W-1:0];
						4'd6:    t2_q  <= prod_r16[R_W-1:0];
						4'd7:    r11_q <= prod_r16[R_W-1:0] + t1_q;
						default: begin
							r21_q <= prod_r16[R_W-1:0];
							r20_q <= -R_W'(sth_q);
						end
					endcase
				end
			end
			ST_LEG_Q: begin
				if (step_q[0]) begin
					case (step_q[3:1])
						3'd1:    qx_q <= acc_r8[Q_W-1:0] + Q_W'($signed({tx_q, 8'b0}));
						3'd3:    qy_q <= acc_r8[Q_W-1:0] + Q_W'($signed({ty_q, 8'b0}));
						3'd5:    qz_q <= acc_r8[Q_W-1:0] + Q_W'($signed({tz_q, 8'b0}));
						default: acc_q <= prod_q[MUL_A_W-1:0];
					endcase
				end
				lo_q     <= -lim_q;
				hi_q     <= lim_q;
				ang_q    <= '0;
				n_q      <= '0;
				status_q <= SOLVE_EXHAUSTED;
			end
			ST_ANG: begin
				if (cordic_done) begin
					ca_q <= cordic_cos;
					sa_q <= cordic_sin;
				end
			end
			ST_HORN: begin
				if (step_q[0]) begin
					case (step_q[3:1])
						3'd0: hca_q <= prod_q[MUL_A_W-1:0];
						3'd1: dx_q <= D_W'(qx_q) - (prod_r24[D_W-1:0]
						              + D_W'($signed({base_x(leg_q), 8'b0})));
						3'd2: dy_q <= D_W'(qy_q) - (prod_r24[D_W-1:0]
						              + D_W'($signed({base_y(leg_q), 8'b0})));
						3'd3: dz_q <= D_W'(qz_q) - prod_r8[D_W-1:0];
						3'd4: sum_q <= prod_q[SQ_W-1:0];
						default: sum_q <= sum_q + prod_q[SQ_W-1:0];
					endcase
				end
			end
			ST_DECIDE: begin
				if (conv) begin
					status_q <= SOLVE_CONVERGED;
				end else begin
					lo_q <= new_lo;
					hi_q <= new_hi;
					n_q  <= n_next[5:0];
					if (pin) begin
						status_q <= SOLVE_PINNED;
					end else begin
						// out of steps keeps the last midpoint
						ang_q <= mid;
					end
				end
			end
			ST_PULSE: begin
				if (step_q[0]) begin
					leg_index    <= leg_q;
					pulse_width  <= pulse_sat;
					solve_status <= status_q;
					last_leg     <= (leg_q == LEG_W'(LEG_COUNT - 1));
					leg_q        <= leg_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/hexik_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, sin/cos in Q16.
// Depends on hexik_pkg (widths, gain, arctangent table).
module hexik_cordic import hexik_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [ANG_W-1:0]  angle,
	output logic                     done,
	output logic signed [TRIG_W-1:0] cos_val,
	output logic signed [TRIG_W-1:0] sin_val
);

	logic                    run_q;
	logic [CSTEP_W-1:0]      cnt_q;
	logic signed [ANG_W-1:0] x_q, y_q, z_q;
	logic                    neg_q;
	logic                    last;
	logic signed [ANG_W-1:0] x_rnd, y_rnd;

	assign last  = (cnt_q == CSTEP_W'(CORDIC_STEPS));
	assign x_rnd = (x_q + 32'sd2048) >>> 12;
	assign y_rnd = (y_q + 32'sd2048) >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (last) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// fold into +-pi/2, flip sign of the result
			if (angle > HALF_PI_Q28) begin
				z_q   <= angle - PI_Q28;
				neg_q <= 1'b1;
			end else if (angle < -HALF_PI_Q28) begin
				z_q   <= angle + PI_Q28;
				neg_q <= 1'b1;
			end else begin
				z_q   <= angle;
				neg_q <= 1'b0;
			end
			x_q <= GAIN_Q28;
			y_q <= '0;
		end else if (run_q) begin
			if (last) begin
				cos_val <= neg_q ? -x_rnd[TRIG_W-1:0] : x_rnd[TRIG_W-1:0];
				sin_val <= neg_q ? -y_rnd[TRIG_W-1:0] : y_rnd[TRIG_W-1:0];
			end else if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> cnt_q);
				y_q <= y_q + (x_q >>> cnt_q);
				z_q <= z_q - atan_q28(cnt_q);
			end else begin
				x_q <= x_q + (y_q >>> cnt_q);
				y_q <= y_q - (x_q >>> cnt_q);
				z_q <= z_q + atan_q28(cnt_q);
			end
		end
	end

endmodule

>>> rtl/hexik_isqrt.sv
// Bit-pair integer square root (floor), one result bit per cycle.
// Depends on hexik_pkg for widths.
module hexik_isqrt import hexik_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_W-1:0]  radicand,
	output logic             done,
	output logic [LEN_W-1:0] root
);

	logic            run_q;
	logic [SQ_W-1:0] v_q, r_q, bit_q;
	logic [SQ_W-1:0] trial;

	assign trial = r_q + bit_q;
	assign root  = r_q[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q == SQ_W'(1)) begin
				run_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule
